FILE: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and codes for the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
   localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
   localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
   localparam logic [1:0] REQ_POP_REAR   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] push_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic [1:0]         status;
      logic [3:0]         entry_count;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

FILE: rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue of signed 32-bit words, one result per item
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req_type, push_value
// rsp      out  rsp_valid/rsp_stall  pop_value, status, entry_count
//
// each item passes through accept, store access and result shown, in turn
// the sequencer steps each item through these over the single-port circular store
// the result waits in its register while rsp_stall is high; no new item
// is taken until it leaves
// synchronous reset empties the queue at once, no clearing pass
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  deq_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output deq_pkg::rsp_payload_type rsp_data
);

   deq_pkg::ctrl_cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   deq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// sequencer: take an item, run it through the datapath, hold the result
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output deq_pkg::ctrl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign cmd.load  = req_valid && (state_ff == S_IDLE);
   assign cmd.exec  = (state_ff == S_EXEC);

endmodule

FILE: rtl/deq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_dp
// circular store, front position and fill count, result register
// ----------------------------------------------------------------------------
module deq_dp #(
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  deq_pkg::ctrl_cmd_type    cmd,
   input  deq_pkg::req_payload_type req_data,
   output deq_pkg::rsp_payload_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [31:0]    mem [DEPTH];

   logic [1:0]     kind_ff;
   logic [31:0]    word_ff;
   logic [AW-1:0]  front_ff;
   logic [AW-1:0]  front_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic [1:0]     status_ff;
   logic [1:0]     status_in;
   logic [31:0]    rd_data_ff;

   logic           is_push;
   logic           is_front;
   logic           full;
   logic           empty;
   logic           do_write;
   logic           do_read;
   logic [SW-1:0]  rear_sum;
   logic [SW-1:0]  rear_wrap;
   logic [AW-1:0]  rear_slot;
   logic [AW-1:0]  front_dec;
   logic [AW-1:0]  front_inc;
   logic [AW-1:0]  addr;
   logic [31:0]    count_ext;

   assign is_push  = !kind_ff[1];
   assign is_front = (kind_ff == deq_pkg::REQ_PUSH_FRONT) ||
                     (kind_ff == deq_pkg::REQ_POP_FRONT);
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_write = cmd.exec && is_push && !full;
   assign do_read  = cmd.exec && !is_push && !empty;

   // rear push goes to front+count, rear pop reads front+count-1
   always_comb begin
      rear_sum = SW'(front_ff) + SW'(count_ff);
      if (!is_push) rear_sum = rear_sum - SW'(1);
      rear_wrap = (rear_sum >= SW'(DEPTH)) ? rear_sum - SW'(DEPTH) : rear_sum;
      rear_slot = rear_wrap[AW-1:0];
   end

   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = deq_pkg::ST_OK;
      addr      = rear_slot;
      case (kind_ff)
         deq_pkg::REQ_PUSH_FRONT: begin
            addr = front_dec;
            if (full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               front_in = front_dec;
               count_in = count_ff + CW'(1);
            end
         end
         deq_pkg::REQ_PUSH_REAR: begin
            if (full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         deq_pkg::REQ_POP_FRONT: begin
            addr = front_ff;
            if (empty) begin
               status_in = deq_pkg::ST_EMPTY;
            end else begin
               front_in = front_inc;
               count_in = count_ff - CW'(1);
            end
         end
         deq_pkg::REQ_POP_REAR: begin
            if (empty) begin
               status_in = deq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = deq_pkg::ST_OK;
         end
      endcase
      if (is_front && !is_push && empty) addr = front_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_data.req_type;
         word_ff <= req_data.push_value;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
      end
   end

   // store
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[addr] <= word_ff;
      end
      if (do_read) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign count_ext = 32'(count_ff);

   assign rsp_data.pop_value   = (!is_push && status_ff == deq_pkg::ST_OK) ?
                                 rd_data_ff : '0;
   assign rsp_data.status      = status_ff;
   assign rsp_data.entry_count = count_ext[3:0];

endmodule
